// ----- sv/phx_pkg.sv -----
// phx_pkg: types, codes and constants shared by the counter generator
// depends on nothing; used by phx_seq and philox_counter_rng_unit

package phx_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] tile_index;
  } req_t;

  typedef struct packed {
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_DRAW
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROUND,
    OP_SEED1,
    OP_SEED2,
    OP_SEED3,
    OP_SEED4,
    OP_SEED5
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } ctrl_t;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  localparam logic [31:0] ROUND_MUL0 = 32'hCD9E8D57;
  localparam logic [31:0] ROUND_MUL1 = 32'hD2511F53;
  localparam logic [63:0] WEYL_BUMP  = 64'hBB67AE85_9E3779B9;

  localparam logic [31:0] AVAL_OFS   = 32'd374761393;
  localparam logic [31:0] AVAL_MUL1  = 32'd668265263;
  localparam logic [31:0] AVAL_MUL2  = 32'd2246822519;
  localparam logic [31:0] AVAL_MUL3  = 32'd3266489917;
  localparam logic [31:0] KHI_MUL    = 32'd1103515245;
  localparam logic [31:0] KLO_MUL    = 32'h045D9F3B;
  localparam logic [31:0] SCALE_B    = 32'd16807;
  localparam logic [31:0] SCALE_C    = 32'd48271;
  localparam logic [31:0] SCALE_D    = 32'd69621;

  localparam int unsigned SEED_STEPS = 5;

endpackage

// ----- sv/phx_mul_pair.sv -----
// phx_mul_pair: the shared pair of 32x32 to 64-bit multipliers
// depends on nothing; operands are chosen by the caller each cycle

module phx_mul_pair (
  input  logic [31:0] a0,
  input  logic [31:0] c0,
  input  logic [31:0] a1,
  input  logic [31:0] c1,
  output logic [63:0] p0,
  output logic [63:0] p1
);

  assign p0 = {32'b0, a0} * {32'b0, c0};
  assign p1 = {32'b0, a1} * {32'b0, c1};

endmodule

// ----- sv/phx_seq.sv -----
// phx_seq: sequencer that steps rounds and reseed hashing over the multipliers
// depends on phx_pkg (state_t, op_t, ctrl_t)

module phx_seq #(
  parameter int unsigned ROUNDS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_kind,
  input  logic           out_busy,
  output logic           req_stall,
  output phx_pkg::ctrl_t ctrl
);

  localparam int unsigned CW = ($clog2(ROUNDS) > 3) ? $clog2(ROUNDS) : 3;
  localparam logic [CW-1:0] LAST_ROUND = CW'(ROUNDS - 1);
  localparam logic [CW-1:0] SEED_LAST  = CW'(phx_pkg::SEED_STEPS - 1);
  localparam logic ONE_ROUND = (ROUNDS == 1);

  phx_pkg::state_t state, state_next;
  logic [CW-1:0]   step, step_next;
  logic            accept;

  assign req_stall = (state != phx_pkg::ST_IDLE) || (ONE_ROUND && out_busy);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= phx_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      phx_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_kind == phx_pkg::KIND_SEED) begin
            state_next = phx_pkg::ST_SEED;
            step_next  = '0;
          end else if (!ONE_ROUND) begin
            state_next = phx_pkg::ST_DRAW;
            step_next  = CW'(1);
          end
        end
      end
      phx_pkg::ST_SEED: begin
        if (step == SEED_LAST) begin
          state_next = phx_pkg::ST_IDLE;
          step_next  = '0;
        end else begin
          step_next = step + CW'(1);
        end
      end
      phx_pkg::ST_DRAW: begin
        if (step == LAST_ROUND) begin
          if (!out_busy) begin
            state_next = phx_pkg::ST_IDLE;
            step_next  = '0;
          end
        end else begin
          step_next = step + CW'(1);
        end
      end
      default: begin
        state_next = phx_pkg::ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_comb begin
    ctrl.op   = phx_pkg::OP_NONE;
    ctrl.last = 1'b0;
    case (state)
      phx_pkg::ST_IDLE: begin
        if (accept && req_kind == phx_pkg::KIND_DRAW) begin
          ctrl.op   = phx_pkg::OP_ROUND;
          ctrl.last = ONE_ROUND;
        end
      end
      phx_pkg::ST_SEED: begin
        case (step)
          CW'(0):  ctrl.op = phx_pkg::OP_SEED1;
          CW'(1):  ctrl.op = phx_pkg::OP_SEED2;
          CW'(2):  ctrl.op = phx_pkg::OP_SEED3;
          CW'(3):  ctrl.op = phx_pkg::OP_SEED4;
          CW'(4):  ctrl.op = phx_pkg::OP_SEED5;
          default: ctrl.op = phx_pkg::OP_NONE;
        endcase
      end
      phx_pkg::ST_DRAW: begin
        if (step == LAST_ROUND && out_busy) begin
          ctrl.op = phx_pkg::OP_NONE;
        end else begin
          ctrl.op   = phx_pkg::OP_ROUND;
          ctrl.last = (step == LAST_ROUND);
        end
      end
      default: begin
        ctrl.op   = phx_pkg::OP_NONE;
        ctrl.last = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/philox_counter_rng_unit.sv -----
// philox_counter_rng_unit: four-word counter generator with 64-bit key
// depends on phx_pkg, phx_mul_pair and phx_seq
//
//   channel | direction | payload       | handshake
//   req     | in        | phx_pkg::req_t | req_valid / req_stall
//   rsp     | out       | phx_pkg::rsp_t | rsp_valid / rsp_stall
//
// a draw runs ROUNDS rounds, one round per cycle on the shared multiplier pair unless
// the output is stalled, the first round running in the cycle of the transfer
// a reseed is the transfer followed by five hashing steps on the same pair
// the result sits in an output register; a draw's last round waits while it is stalled
// rst clears the counter words, the key and all control state

module philox_counter_rng_unit #(
  parameter int unsigned ROUNDS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  phx_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output phx_pkg::rsp_t rsp
);

  phx_pkg::ctrl_t ctrl;
  logic [31:0]    words [4];
  logic [31:0]    key_hi, key_lo;
  logic [7:0]     tile;
  logic [31:0]    a0, c0, a1, c1;
  logic [63:0]    p0, p1;
  logic [31:0]    n0, n1, n2, n3;
  logic [63:0]    key_sum;
  logic [31:0]    seed_base;

  phx_seq #(.ROUNDS(ROUNDS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .out_busy  (rsp_valid && rsp_stall),
    .req_stall (req_stall),
    .ctrl      (ctrl)
  );

  phx_mul_pair u_mul (
    .a0 (a0),
    .c0 (c0),
    .a1 (a1),
    .c1 (c1),
    .p0 (p0),
    .p1 (p1)
  );

  assign seed_base = {24'b0, tile} + phx_pkg::AVAL_OFS;
  assign n0        = p1[63:32] ^ words[1] ^ key_lo;
  assign n1        = p1[31:0];
  assign n2        = p0[63:32] ^ words[3] ^ key_hi;
  assign n3        = p0[31:0];
  assign key_sum   = {key_hi, key_lo} + phx_pkg::WEYL_BUMP;

  always_comb begin
    a0 = words[0];
    c0 = phx_pkg::ROUND_MUL0;
    a1 = words[2];
    c1 = phx_pkg::ROUND_MUL1;
    case (ctrl.op)
      phx_pkg::OP_SEED1: begin
        a0 = {seed_base[14:0], seed_base[31:15]};
        c0 = phx_pkg::AVAL_MUL1;
        a1 = {24'b0, tile ^ (tile >> 1)};
        c1 = phx_pkg::KHI_MUL;
      end
      phx_pkg::OP_SEED2: begin
        a0 = words[0] ^ (words[0] >> 15);
        c0 = phx_pkg::AVAL_MUL2;
        a1 = key_hi ^ (key_hi >> 3);
        c1 = phx_pkg::KHI_MUL;
      end
      phx_pkg::OP_SEED3: begin
        a0 = words[0] ^ (words[0] >> 13);
        c0 = phx_pkg::AVAL_MUL3;
        a1 = {24'b0, tile};
        c1 = phx_pkg::KLO_MUL;
      end
      phx_pkg::OP_SEED4: begin
        a0 = words[0] ^ (words[0] >> 16);
        c0 = phx_pkg::SCALE_B;
        a1 = key_lo ^ (key_lo >> 16);
        c1 = phx_pkg::KLO_MUL;
      end
      phx_pkg::OP_SEED5: begin
        a0 = words[0];
        c0 = phx_pkg::SCALE_C;
        a1 = words[0];
        c1 = phx_pkg::SCALE_D;
      end
      default: begin
        a0 = words[0];
        c0 = phx_pkg::ROUND_MUL0;
        a1 = words[2];
        c1 = phx_pkg::ROUND_MUL1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      tile <= req.tile_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words[0] <= '0;
      words[1] <= '0;
      words[2] <= '0;
      words[3] <= '0;
      key_hi   <= '0;
      key_lo   <= '0;
    end else begin
      case (ctrl.op)
        phx_pkg::OP_ROUND: begin
          words[0] <= n0;
          words[1] <= n1;
          words[2] <= n2;
          words[3] <= n3;
          key_hi   <= key_sum[63:32];
          key_lo   <= key_sum[31:0];
        end
        phx_pkg::OP_SEED1, phx_pkg::OP_SEED2: begin
          words[0] <= p0[31:0];
          key_hi   <= p1[31:0];
        end
        phx_pkg::OP_SEED3: begin
          words[0] <= p0[31:0];
          key_lo   <= p1[31:0];
        end
        phx_pkg::OP_SEED4: begin
          words[0] <= words[0] ^ (words[0] >> 16);
          words[1] <= p0[31:0];
          key_hi   <= key_hi ^ (key_hi >> 16);
          key_lo   <= p1[31:0];
        end
        phx_pkg::OP_SEED5: begin
          words[2] <= p0[31:0];
          words[3] <= p1[31:0];
          key_lo   <= key_lo ^ (key_lo >> 16);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.last) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.last) begin
      rsp.word_a <= n0;
      rsp.word_b <= n1;
      rsp.word_c <= n2;
      rsp.word_d <= n3;
    end
  end

  a_last_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.last |-> !(rsp_valid && rsp_stall))
    else $error("result written over a stalled transfer");

  a_seed_no_result: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op != phx_pkg::OP_NONE && ctrl.op != phx_pkg::OP_ROUND) |-> !ctrl.last)
    else $error("reseed step produced a result");

  a_result_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(ctrl.last))
    else $error("result raised without a final round");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("stalled result dropped");

endmodule
